FILE: src/swsnd_pkg.sv
// swsnd_pkg: shared types, codes and constants of the sliding window sender
// beat structs, job struct passed from front to back, configuration struct
// no dependencies
`default_nettype none

package swsnd_pkg;

  // sizing defaults and fixed protocol constants
  localparam int WINDOW_SLOTS_DEF  = 32;
  localparam int MAX_PAYLOAD       = 1024;
  localparam int QUEUE_BYTES       = 65536;
  localparam int CTRL_HEADER_BYTES = 8;
  localparam int NEAR_TOP          = 60000;
  localparam int NEAR_BOTTOM       = 5000;

  // configuration port geometry
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_WIN  = 2'd0,
    CFG_OWN_ID   = 2'd1,
    CFG_PROTO    = 2'd2,
    CFG_ACK_TYPE = 2'd3
  } swsnd_cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_SEGMENT = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_UNUSED  = 2'd3
  } swsnd_cmd_e;

  typedef enum logic [1:0] {
    KIND_NEW    = 2'd0,
    KIND_RETX   = 2'd1,
    KIND_STATUS = 2'd2
  } swsnd_kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } swsnd_status_e;

  typedef enum logic [1:0] {
    JOB_APPEND  = 2'd0,
    JOB_ACK     = 2'd1,
    JOB_TIMEOUT = 2'd2,
    JOB_REPORT  = 2'd3
  } swsnd_job_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  connection_id;
    logic [16:0] append_length;
    logic [10:0] segment_length;
    logic [7:0]  segment_type;
    logic [7:0]  segment_protocol;
    logic [15:0] ack_number;
    logic [15:0] peer_window;
  } swsnd_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sequence_low;
    logic [4:0]  slot;
    logic [10:0] payload_length;
    logic [31:0] stream_offset;
    logic [1:0]  status;
    logic        last;
  } swsnd_out_t;

  typedef struct packed {
    logic [5:0] max_win;
    logic [7:0] own_id;
    logic [7:0] proto;
    logic [7:0] ack_type;
  } swsnd_cfg_t;

  typedef struct packed {
    swsnd_job_e    op;
    swsnd_status_e status;
    logic [16:0]   alen;
    logic [15:0]   ack16;
    logic [15:0]   pwin;
  } swsnd_job_t;

endpackage

`default_nettype wire

FILE: src/sliding_window_sender.sv
// sliding_window_sender: go-back-n sender controller, top level
// holds the configuration registers, joins swsnd_front and swsnd_back
// depends on swsnd_pkg, swsnd_front, swsnd_back
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------
//  in       | in_valid_i / in_ready_o   | in_data_i  (swsnd_in_t)
//  out      | out_valid_o / out_ready_i | out_data_o (swsnd_out_t)
//  cfg      | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// the front classifies a beat in the cycle it arrives and queues it (two jobs)
// the back takes one job at a time: dispatch from idle, ack extend then slide,
// a read and an output step per resent segment and a closing read to end the sweep,
// a fill step per new segment and a last one to leave the fill, then the status beat
// all control state is cleared by rst_ni; the slot memory needs no clearing
// a stalled output holds the engine in place, the input queue keeps filling
`default_nettype none

module sliding_window_sender import swsnd_pkg::*; #(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire swsnd_in_t              in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output swsnd_out_t                  out_data_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);

  swsnd_cfg_t       cfg_q;
  logic             job_valid;
  swsnd_job_t       job;
  logic             job_pop;
  logic [CNT_W-1:0] flight;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_win  <= 6'd32;
      cfg_q.own_id   <= 8'd1;
      cfg_q.proto    <= 8'd0;
      cfg_q.ack_type <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_WIN:  cfg_q.max_win  <= cfg_wdata_i[5:0];
        CFG_OWN_ID:   cfg_q.own_id   <= cfg_wdata_i;
        CFG_PROTO:    cfg_q.proto    <= cfg_wdata_i;
        CFG_ACK_TYPE: cfg_q.ack_type <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // classify and queue
  swsnd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // window engine
  swsnd_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .flight_o    (flight)
  );

`ifndef SYNTH
  // only the status beat closes a run
  a_last_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.kind == KIND_STATUS) == out_data_o.last))
    else $error("last flag and status kind disagree");

  // new segments carry between one and a full payload
  a_new_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == KIND_NEW)) |->
      ((out_data_o.payload_length != 11'd0) &&
       (out_data_o.payload_length <= 11'(MAX_PAYLOAD))))
    else $error("new segment length out of range");

  // segments in flight never exceed the slot memory
  a_flight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight <= CNT_W'(WINDOW_SLOTS))
    else $error("more segments in flight than window slots");
`endif

endmodule

`default_nettype wire

FILE: src/swsnd_front.sv
// swsnd_front: classifies incoming beats into jobs and queues them
// two-entry job queue decouples the input channel from the back engine
// depends on swsnd_pkg
`default_nettype none

module swsnd_front import swsnd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire swsnd_in_t  in_data_i,
  input  wire swsnd_cfg_t cfg_i,
  output logic            job_valid_o,
  output swsnd_job_t      job_o,
  input  wire logic       job_pop_i
);

  logic [1:0] cnt_q;
  logic       wr_q;
  logic       rd_q;
  swsnd_job_t fifo_q [2];
  swsnd_job_t job_d;
  logic       conn_ok;
  logic       hdr_ok;
  logic       push;
  logic       pop;

  // classify the beat: reject early, hand valid work to the back
  always_comb begin
    job_d.op     = JOB_REPORT;
    job_d.status = ST_IGNORED;
    job_d.alen   = in_data_i.append_length;
    job_d.ack16  = in_data_i.ack_number;
    job_d.pwin   = in_data_i.peer_window;
    conn_ok = (in_data_i.connection_id == cfg_i.own_id);
    hdr_ok  = (in_data_i.segment_length >= 11'(CTRL_HEADER_BYTES)) &&
              (in_data_i.segment_type == cfg_i.ack_type) &&
              (in_data_i.segment_protocol == cfg_i.proto);
    case (in_data_i.command)
      CMD_APPEND: begin
        if (conn_ok) begin
          job_d.op     = JOB_APPEND;
          job_d.status = ST_OK;
        end else begin
          job_d.status = ST_UNKNOWN;
        end
      end
      CMD_SEGMENT: begin
        if (!conn_ok) begin
          job_d.status = ST_UNKNOWN;
        end else if (hdr_ok) begin
          job_d.op     = JOB_ACK;
          job_d.status = ST_OK;
        end
      end
      CMD_TIMEOUT: begin
        job_d.op     = JOB_TIMEOUT;
        job_d.status = ST_OK;
      end
      default: ;
    endcase
  end

  // queue handshake
  assign in_ready_o  = (cnt_q != 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_pop_i && job_valid_o;

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= job_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/swsnd_back.sv
// swsnd_back: window engine, slot memory and output register
// runs one job at a time: ack slide, resend sweep, window fill, status beat
// depends on swsnd_pkg
`default_nettype none

module swsnd_back import swsnd_pkg::*; #(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
  localparam int SLOT_W = $clog2(WINDOW_SLOTS),
  localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1)
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire swsnd_cfg_t cfg_i,
  input  wire logic       job_valid_i,
  input  wire swsnd_job_t job_i,
  output logic            job_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output swsnd_out_t      out_data_o,
  output logic [CNT_W-1:0] flight_o
);

  localparam logic [SLOT_W:0]   SLOTS_X   = (SLOT_W + 1)'(WINDOW_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [CNT_W-1:0]  SLOTS_C   = CNT_W'(WINDOW_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACK_EXT,
    S_ACK_SLIDE,
    S_RETX_RD,
    S_RETX_OUT,
    S_FILL,
    S_STATUS
  } state_e;

  typedef struct packed {
    logic [10:0] len;
    logic [31:0] off;
  } slot_ent_t;

  state_e            state_q;
  logic [31:0]       base_q;
  logic [31:0]       next_q;
  logic [SLOT_W-1:0] base_slot_q;
  logic [SLOT_W-1:0] next_slot_q;
  logic [CNT_W-1:0]  flight_q;
  logic [15:0]       peer_q;
  logic [16:0]       pend_q;
  logic [31:0]       pend_off_q;
  swsnd_status_e     status_q;
  logic [15:0]       ack16_q;
  logic [15:0]       pwin_q;
  logic [31:0]       dist_q;
  logic [CNT_W-1:0]  idx_q;
  logic [SLOT_W-1:0] ptr_q;
  logic              out_valid_q;
  swsnd_out_t        out_q;
  slot_ent_t         slot_mem [WINDOW_SLOTS];
  slot_ent_t         rd_ent_q;

  logic              out_free;
  logic [6:0]        max_win_x;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  eff;
  logic              can_fill;
  logic [10:0]       fill_len;
  logic              fill_we;
  logic [15:0]       hi_ext;
  logic [31:0]       ack_ext;
  logic              slide_ok;
  logic [CNT_W-1:0]  dist_cnt;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] base_slot_slid;
  logic [SLOT_W-1:0] next_slot_inc;
  logic [SLOT_W-1:0] ptr_inc;
  logic [17:0]       pend_sum;
  logic              queue_full;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign flight_o    = flight_q;
  assign job_pop_o   = (state_q == S_IDLE) && job_valid_i;

  // effective window: register cap clamped to the slot count (zero taken as one), then to the peer window
  always_comb begin
    max_win_x = {1'b0, cfg_i.max_win};
    if (max_win_x > 7'(WINDOW_SLOTS)) begin
      cap = SLOTS_C;
    end else if (max_win_x == 7'd0) begin
      cap = CNT_W'(1);
    end else begin
      cap = CNT_W'(max_win_x);
    end
    eff = cap;
    if (peer_q < 16'(cap)) begin
      eff = (peer_q > 16'd1) ? CNT_W'(peer_q) : CNT_W'(1);
    end
  end

  // next segment of the pending queue
  assign can_fill = (flight_q < eff) && (pend_q != 17'd0);
  assign fill_len = (pend_q < 17'(MAX_PAYLOAD)) ? pend_q[10:0] : 11'(MAX_PAYLOAD);
  assign fill_we  = (state_q == S_FILL) && can_fill && out_free;

  // 16-bit ack extended against the window base
  always_comb begin
    hi_ext = base_q[31:16];
    if ((base_q[15:0] > 16'(NEAR_TOP)) && (ack16_q < 16'(NEAR_BOTTOM))) begin
      hi_ext = base_q[31:16] + 16'd1;
    end else if ((base_q[15:0] < 16'(NEAR_BOTTOM)) && (ack16_q > 16'(NEAR_TOP))) begin
      hi_ext = base_q[31:16] - 16'd1;
    end
    ack_ext = {hi_ext, ack16_q};
  end

  // slide distance and wrapped slot pointers
  assign slide_ok       = (dist_q != 32'd0) && (dist_q <= 32'(flight_q));
  assign dist_cnt       = dist_q[CNT_W-1:0];
  assign slot_sum       = (SLOT_W + 1)'(base_slot_q) + (SLOT_W + 1)'(dist_cnt);
  assign base_slot_slid = (slot_sum >= SLOTS_X) ? SLOT_W'(slot_sum - SLOTS_X)
                                                : SLOT_W'(slot_sum);
  assign next_slot_inc  = (next_slot_q == LAST_SLOT) ? '0 : next_slot_q + 1'b1;
  assign ptr_inc        = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;

  // append bound check
  assign pend_sum   = {1'b0, pend_q} + {1'b0, job_i.alen};
  assign queue_full = pend_sum > 18'(QUEUE_BYTES);

  // job sequencer with window state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= 32'd0;
      next_q      <= 32'd0;
      base_slot_q <= '0;
      next_slot_q <= '0;
      flight_q    <= '0;
      peer_q      <= 16'(WINDOW_SLOTS);
      pend_q      <= 17'd0;
      pend_off_q  <= 32'd0;
      status_q    <= ST_OK;
      ack16_q     <= 16'd0;
      pwin_q      <= 16'd0;
      dist_q      <= 32'd0;
      idx_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            status_q <= job_i.status;
            ack16_q  <= job_i.ack16;
            pwin_q   <= job_i.pwin;
            case (job_i.op)
              JOB_APPEND: begin
                if (queue_full) begin
                  status_q <= ST_FULL;
                end else begin
                  pend_q <= pend_sum[16:0];
                end
                state_q <= S_FILL;
              end
              JOB_ACK: begin
                state_q <= S_ACK_EXT;
              end
              JOB_TIMEOUT: begin
                idx_q   <= '0;
                ptr_q   <= base_slot_q;
                state_q <= S_RETX_RD;
              end
              default: begin
                state_q <= S_STATUS;
              end
            endcase
          end
        end
        S_ACK_EXT: begin
          dist_q  <= ack_ext - base_q;
          state_q <= S_ACK_SLIDE;
        end
        S_ACK_SLIDE: begin
          if (pwin_q != 16'd0) begin
            peer_q <= pwin_q;
          end
          if (slide_ok) begin
            base_q      <= base_q + dist_q;
            base_slot_q <= base_slot_slid;
            flight_q    <= flight_q - dist_cnt;
          end
          state_q <= S_FILL;
        end
        S_RETX_RD: begin
          state_q <= (idx_q == flight_q) ? S_FILL : S_RETX_OUT;
        end
        S_RETX_OUT: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_q.kind           <= KIND_RETX;
            out_q.sequence_low   <= base_q[15:0] + 16'(idx_q);
            out_q.slot           <= 5'(ptr_q);
            out_q.payload_length <= rd_ent_q.len;
            out_q.stream_offset  <= rd_ent_q.off;
            out_q.status         <= ST_OK;
            out_q.last           <= 1'b0;
            idx_q                <= idx_q + 1'b1;
            ptr_q                <= ptr_inc;
            state_q              <= S_RETX_RD;
          end
        end
        S_FILL: begin
          if (can_fill) begin
            if (out_free) begin
              out_valid_q          <= 1'b1;
              out_q.kind           <= KIND_NEW;
              out_q.sequence_low   <= next_q[15:0];
              out_q.slot           <= 5'(next_slot_q);
              out_q.payload_length <= fill_len;
              out_q.stream_offset  <= pend_off_q;
              out_q.status         <= ST_OK;
              out_q.last           <= 1'b0;
              next_q               <= next_q + 32'd1;
              next_slot_q          <= next_slot_inc;
              flight_q             <= flight_q + 1'b1;
              pend_q               <= pend_q - 17'(fill_len);
              pend_off_q           <= pend_off_q + 32'(fill_len);
            end
          end else begin
            state_q <= S_STATUS;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_q.kind           <= KIND_STATUS;
            out_q.sequence_low   <= 16'd0;
            out_q.slot           <= 5'd0;
            out_q.payload_length <= 11'd0;
            out_q.stream_offset  <= 32'd0;
            out_q.status         <= status_q;
            out_q.last           <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // per-slot length and offset, written on fill, read for resend
  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      slot_mem[next_slot_q] <= '{len: fill_len, off: pend_off_q};
    end
    rd_ent_q <= slot_mem[ptr_q];
  end

endmodule

`default_nettype wire
